// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks sampled on clk, switched off while rst is high.
`define ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/cwl_pkg.sv =====
`default_nettype none

package cwl_pkg;

  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;

  localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  localparam int OP_BITS     = 2;
  localparam int VALUE_BITS  = 32;
  localparam int POS_BITS    = 4;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 5;

  // wide enough to compare a position against the count
  localparam int WIDE_BITS = ((CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS) + 1;

  localparam logic [OP_BITS-1:0] OP_APPEND       = 2'd0;
  localparam logic [OP_BITS-1:0] OP_REMOVE_VALUE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_REMOVE_AT    = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [OP_BITS-1:0]    operation;
    logic [VALUE_BITS-1:0] value;
    logic [POS_BITS-1:0]   position;
  } cwl_request_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  count;
  } cwl_result_t;

endpackage

`default_nettype wire

// ===== hdl/cwl_req_if.sv =====
`default_nettype none

interface cwl_req_if import cwl_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [OP_BITS-1:0]    operation;
  logic [VALUE_BITS-1:0] value;
  logic [POS_BITS-1:0]   position;

  modport source (output valid, operation, value, position, input ready);
  modport sink   (input valid, operation, value, position, output ready);
endinterface

`default_nettype wire

// ===== hdl/cwl_rsp_if.sv =====
`default_nettype none

interface cwl_rsp_if import cwl_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [COUNT_BITS-1:0]  count;

  modport source (output valid, status, count, input ready);
  modport sink   (input valid, status, count, output ready);
endinterface

`default_nettype wire

// ===== hdl/cwl_seq.sv =====
`default_nettype none
`include "assert_macros.svh"

module cwl_seq import cwl_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire cwl_request_t req,
  output logic              idle,
  output logic              res_valid,
  input  wire logic         res_ready,
  output cwl_result_t       res
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t                 state, state_next;
  logic [CNT_BITS-1:0]    used, used_next;
  logic [CNT_BITS-1:0]    idx, idx_next;
  logic [WORD_BITS-1:0]   key, key_next;
  logic                   cmp_vld, cmp_vld_next;
  logic [IDX_BITS-1:0]    cmp_idx, cmp_idx_next;
  logic                   sh_vld, sh_vld_next;
  logic [IDX_BITS-1:0]    sh_addr, sh_addr_next;
  logic [STATUS_BITS-1:0] status, status_next;

  logic [WORD_BITS-1:0] mem [CAPACITY];
  logic [WORD_BITS-1:0] rdata;
  logic                 rd_en;
  logic [IDX_BITS-1:0]  raddr;
  logic                 we;
  logic [IDX_BITS-1:0]  waddr;
  logic [WORD_BITS-1:0] wdata;

  logic [WORD_BITS-1:0] req_word;
  logic                 hit;
  logic                 last;
  logic                 shift_end;

  assign req_word = WORD_BITS'(req.value);
  assign raddr    = idx[IDX_BITS-1:0];
  assign hit      = cmp_vld && (rdata == key);
  assign last     = cmp_vld && ((CNT_BITS'(cmp_idx) + CNT_BITS'(1)) == used);

  always_comb begin
    state_next   = state;
    used_next    = used;
    idx_next     = idx;
    key_next     = key;
    cmp_vld_next = 1'b0;
    cmp_idx_next = cmp_idx;
    sh_vld_next  = 1'b0;
    sh_addr_next = sh_addr;
    status_next  = status;
    rd_en        = 1'b0;
    we           = 1'b0;
    waddr        = used[IDX_BITS-1:0];
    wdata        = req_word;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          status_next = ST_OK;
          state_next  = S_DONE;
          unique case (req.operation)
            OP_APPEND: begin
              if (used == CNT_BITS'(CAPACITY)) begin
                status_next = ST_FULL;
              end else begin
                we        = 1'b1;
                used_next = used + CNT_BITS'(1);
              end
            end
            OP_REMOVE_VALUE: begin
              key_next = req_word;
              idx_next = '0;
              if (used == '0) begin
                status_next = ST_NOT_FOUND;
              end else begin
                state_next = S_SEARCH;
              end
            end
            OP_REMOVE_AT: begin
              if (WIDE_BITS'(req.position) >= WIDE_BITS'(used)) begin
                status_next = ST_BAD_INDEX;
              end else begin
                idx_next   = CNT_BITS'(req.position) + CNT_BITS'(1);
                state_next = S_SHIFT;
              end
            end
            default: ;  // unused code: nothing changes
          endcase
        end
      end
      S_SEARCH: begin
        // read entry idx while comparing the one read last cycle
        rd_en        = (idx < used);
        cmp_vld_next = rd_en;
        cmp_idx_next = idx[IDX_BITS-1:0];
        if (rd_en) begin
          idx_next = idx + CNT_BITS'(1);
        end
        if (hit) begin
          idx_next     = CNT_BITS'(cmp_idx) + CNT_BITS'(1);
          cmp_vld_next = 1'b0;
          state_next   = S_SHIFT;
        end else if (last) begin
          status_next  = ST_NOT_FOUND;
          cmp_vld_next = 1'b0;
          state_next   = S_DONE;
        end
      end
      S_SHIFT: begin
        // read entry idx, write it one slot lower in the next cycle
        rd_en        = (idx < used);
        sh_vld_next  = rd_en;
        sh_addr_next = idx[IDX_BITS-1:0];
        if (rd_en) begin
          idx_next = idx + CNT_BITS'(1);
        end
        if (sh_vld) begin
          we    = 1'b1;
          waddr = sh_addr - IDX_BITS'(1);
          wdata = rdata;
        end
        if (!rd_en && !sh_vld) begin
          used_next  = used - CNT_BITS'(1);
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      used    <= '0;
      cmp_vld <= 1'b0;
      sh_vld  <= 1'b0;
    end else begin
      state   <= state_next;
      used    <= used_next;
      cmp_vld <= cmp_vld_next;
      sh_vld  <= sh_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    key     <= key_next;
    cmp_idx <= cmp_idx_next;
    sh_addr <= sh_addr_next;
    status  <= status_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  assign idle       = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign res.status = status;
  assign res.count  = COUNT_BITS'(used);

  assign shift_end = (state == S_SHIFT) && (state_next == S_DONE);

  `ASSERT_HOLDS(a_used_bound, used <= CNT_BITS'(CAPACITY))
  `ASSERT_IMPL(a_cmp_in_range, cmp_vld && (state == S_SEARCH), CNT_BITS'(cmp_idx) < used)
  `ASSERT_IMPL(a_shift_no_underflow, sh_vld && (state == S_SHIFT), sh_addr != '0)
  `ASSERT_NEXT(a_shift_drops_one, shift_end, used == ($past(used) - CNT_BITS'(1)))

endmodule

`default_nettype wire

// ===== hdl/compacting_word_list_top.sv =====
// Ordered list of up to CAPACITY words with an entry count.
// req channel: one request per operation (append, remove first entry equal
// to value, remove entry at position). rsp channel: one result per request
// with a status code and the count after the operation.
// A request is taken only while the sequencer is idle; the list is held in a
// single-port-read entry memory that is walked one entry per cycle.
// Remove by value reads entries from the first until one matches, then shifts
// each later entry down one slot; remove at position does only the shift.
// The result sits in an output register; the next request is accepted while
// it waits. If rsp stalls, a second finished result holds the sequencer
// until the register frees up.
// Reset (rst, synchronous) empties the list and holds req.ready low; entry
// contents are not cleared and need no clearing pass.
`default_nettype none

module compacting_word_list_top import cwl_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  cwl_req_if.sink  req,
  cwl_rsp_if.source rsp
);

  cwl_request_t seq_req;
  cwl_result_t  seq_res;
  logic         seq_idle;
  logic         seq_res_valid;
  logic         seq_res_ready;
  logic         start;

  logic         out_vld;
  cwl_result_t  out_res;

  assign seq_req.operation = req.operation;
  assign seq_req.value     = req.value;
  assign seq_req.position  = req.position;

  assign req.ready = seq_idle && !rst;
  assign start     = req.valid && seq_idle && !rst;

  assign seq_res_ready = !out_vld || rsp.ready;

  cwl_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (seq_req),
    .idle      (seq_idle),
    .res_valid (seq_res_valid),
    .res_ready (seq_res_ready),
    .res       (seq_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (seq_res_valid && seq_res_ready) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_res_valid && seq_res_ready) begin
      out_res <= seq_res;
    end
  end

  assign rsp.valid  = out_vld;
  assign rsp.status = out_res.status;
  assign rsp.count  = out_res.count;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cwl_pkg::*;

  // the block ignores the one code the package leaves unnamed
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1500;
  localparam int SETTLE_CYCLES = CAPACITY + 8;

  typedef struct packed {
    logic [CAPACITY-1:0][WORD_BITS-1:0] words;
    logic [CNT_BITS-1:0]                used;
  } word_list_t;

  typedef struct packed {
    cwl_request_t req;
    logic         drain_first;
    logic [7:0]   gap_after;
  } queued_request_t;

  logic clk = 1'b0;
  logic rst;

  cwl_req_if req_ch ();
  cwl_rsp_if rsp_ch ();

  compacting_word_list_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #2 clk = ~clk;

  queued_request_t ops_to_send[$];
  cwl_result_t     outcomes_due[$];
  word_list_t      list_now;
  word_list_t      list_plan;
  int              mismatches = 0;
  int              idle_left;
  int              stall_left;
  int              send_calm_left = 0;
  int              rsp_calm_left = 0;
  logic            drain_next = 1'b0;
  queued_request_t next_op;
  cwl_request_t    seen_req;
  cwl_result_t     want;

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Applies one request to a list and returns the status and new count.
  function automatic cwl_result_t apply_list_op(inout word_list_t s, input cwl_request_t r);
    cwl_result_t res;
    int          gap_at;
    int          i;
    res.status = ST_OK;
    gap_at = -1;
    case (r.operation)
      OP_APPEND: begin
        if (s.used >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          s.words[s.used[IDX_BITS-1:0]] = r.value[WORD_BITS-1:0];
          s.used = s.used + 1'b1;
        end
      end
      OP_REMOVE_VALUE: begin
        for (i = 0; i < s.used; i++)
          if (gap_at < 0 && s.words[i] == r.value[WORD_BITS-1:0])
            gap_at = i;
        if (gap_at < 0)
          res.status = ST_NOT_FOUND;
      end
      OP_REMOVE_AT: begin
        if (r.position >= s.used)
          res.status = ST_BAD_INDEX;
        else
          gap_at = int'(r.position);
      end
      default: ;
    endcase
    if (gap_at >= 0) begin
      for (i = gap_at; i + 1 < s.used; i++)
        s.words[i] = s.words[i + 1];
      s.used = s.used - 1'b1;
    end
    res.count = s.used;
    return res;
  endfunction

  // mostly short, a few long
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 7)
      return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic queue_request(input logic [OP_BITS-1:0] op, input logic [VALUE_BITS-1:0] val,
                               input logic [POS_BITS-1:0] pos);
    queued_request_t item;
    item.req.operation = op;
    item.req.value = val;
    item.req.position = pos;
    item.drain_first = drain_next;
    drain_next = 1'b0;
    if (send_calm_left > 0) begin
      send_calm_left--;
      item.gap_after = '0;
    end else if ($urandom_range(0, 99) == 0) begin
      send_calm_left = $urandom_range(30, 120);
      item.gap_after = '0;
    end else begin
      item.gap_after = $urandom_range(0, 1) ? 8'd0 : 8'(idle_len());
    end
    void'(apply_list_op(list_plan, item.req));
    ops_to_send.push_back(item);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    // a narrow range makes duplicates, so first-match order matters
    if ($urandom_range(0, 9) < 4)
      return $urandom_range(0, 7);
    return $urandom;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        seen_req.operation = req_ch.operation;
        seen_req.value = req_ch.value;
        seen_req.position = req_ch.position;
        outcomes_due.push_back(apply_list_op(list_now, seen_req));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (idle_left > 0) begin
          idle_left--;
          req_ch.valid <= 1'b0;
        end else if (ops_to_send.size() != 0 &&
                     !(ops_to_send[0].drain_first && outcomes_due.size() != 0)) begin
          next_op = ops_to_send.pop_front();
          req_ch.operation <= next_op.req.operation;
          req_ch.value <= next_op.req.value;
          req_ch.position <= next_op.req.position;
          req_ch.valid <= 1'b1;
          idle_left = int'(next_op.gap_after);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (outcomes_due.size() == 0) begin
          note_mismatch("result with no request outstanding");
        end else begin
          want = outcomes_due.pop_front();
          if (rsp_ch.status !== want.status)
            note_mismatch($sformatf("status code %0d, want %0d", rsp_ch.status, want.status));
          if (rsp_ch.count !== want.count)
            note_mismatch($sformatf("count %0d, want %0d", rsp_ch.count, want.count));
        end
      end
      if (rsp_calm_left > 0)
        rsp_calm_left--;
      else if ($urandom_range(0, 299) == 0)
        rsp_calm_left = $urandom_range(50, 200);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (rsp_calm_left == 0 && $urandom_range(0, 7) == 0)
          stall_left = idle_len();
      end
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int i;
    int counted;
    int target;
    int grow;
    logic [VALUE_BITS-1:0] v;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_APPEND;
    req_ch.value = '0;
    req_ch.position = '0;
    rsp_ch.ready = 1'b0;
    list_now = '0;
    list_plan = '0;

    // empty list corner cases
    queue_request(OP_REMOVE_VALUE, 32'h0, 4'd0);
    queue_request(OP_REMOVE_AT, 32'h0, 4'd0);
    queue_request(OP_REMOVE_AT, '1, 4'd15);
    // fill to capacity, with a duplicate and the value extremes
    for (i = 0; i < CAPACITY; i++) begin
      case (i)
        0: v = '0;
        1: v = '1;
        2, 5: v = 32'h8000_0001;
        default: v = $urandom;
      endcase
      queue_request(OP_APPEND, v, POS_BITS'($urandom_range(0, 15)));
    end
    drain_next = 1'b1;
    queue_request(OP_APPEND, 32'h1234_5678, 4'd0);
    queue_request(OP_REMOVE_VALUE, 32'h8000_0001, 4'd0);
    queue_request(OP_REMOVE_AT, 32'h0, 4'd14);
    queue_request(OP_REMOVE_AT, 32'h0, 4'd14);
    queue_request(OP_REMOVE_AT, 32'h0, 4'd0);
    queue_request(OP_REMOVE_VALUE, '1, 4'd15);
    queue_request(OP_REMOVE_VALUE, 32'h1234_5678, 4'd7);
    queue_request(OP_UNUSED, '1, 4'd15);

    // random part: a wandering target count drives the list to both ends
    counted = 0;
    target = CAPACITY / 2;
    while (counted < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 3))
          0: target = 0;
          1: target = CAPACITY;
          default: target = $urandom_range(0, CAPACITY);
        endcase
      end
      if (counted % 400 == 0)
        drain_next = 1'b1;
      if ($urandom_range(0, 99) < 3) begin
        queue_request(OP_UNUSED, $urandom, POS_BITS'($urandom_range(0, 15)));
      end else begin
        grow = (list_plan.used < target) ? 75 : (list_plan.used > target) ? 25 : 50;
        if ($urandom_range(0, 99) < grow) begin
          queue_request(OP_APPEND, pick_value(), POS_BITS'($urandom_range(0, 15)));
        end else if ($urandom_range(0, 1)) begin
          if (list_plan.used != 0 && $urandom_range(0, 3) != 0)
            v = list_plan.words[$urandom_range(0, list_plan.used - 1)];
          else
            v = pick_value();
          queue_request(OP_REMOVE_VALUE, v, POS_BITS'($urandom_range(0, 15)));
        end else begin
          if (list_plan.used != 0 && $urandom_range(0, 4) != 0)
            queue_request(OP_REMOVE_AT, $urandom,
                          POS_BITS'($urandom_range(0, list_plan.used - 1)));
          else
            queue_request(OP_REMOVE_AT, $urandom, POS_BITS'($urandom_range(0, 15)));
        end
        counted++;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (ops_to_send.size() != 0 || req_ch.valid || outcomes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (outcomes_due.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));

    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
